/* rtl/state_space_filter_step_macros.svh */
// Assertion macros used by the top level of the state-space filter RTL.
// Sampled on clk, disabled while rst_n is low; no other dependencies.
`ifndef STATE_SPACE_FILTER_STEP_MACROS_SVH
`define STATE_SPACE_FILTER_STEP_MACROS_SVH

// Same-cycle implication.
`define SSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssf_pkg.sv */
// Shared types and constants of the state-space filter.
// No dependencies; used by every module of the block.
package ssf_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 18;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 48;
    localparam int COEF_IDX_W  = 5;
    localparam int COL_MAX_W   = 4;
    localparam int CFG_IDX_W   = 3;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_B    = 3'd4;

    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 24'sh800000;

    typedef struct packed {
        logic                 start;
        logic                 mul_en;
        logic [COL_MAX_W-1:0] col;
    } ssf_ctrl_t;

    typedef struct packed {
        logic                         en;
        logic [COEF_IDX_W-1:0]        index;
        logic signed [COEF_W-1:0]     value;
    } ssf_coef_wr_t;

endpackage

/* rtl/ssf_lane.sv */
// One multiply-accumulate lane: holds one row of coefficients, one column per cycle.
// Depends on ssf_pkg for widths and control types.
module ssf_lane #(
    parameter int NUM_STATES = 4,
    parameter int NUM_INPUTS = 2,
    parameter int LANE       = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssf_pkg::ssf_ctrl_t                    ctrl,
    input  ssf_pkg::ssf_coef_wr_t                 coef_wr,
    input  logic signed [ssf_pkg::SAMPLE_W-1:0]   opnd,
    output logic signed [ssf_pkg::ACC_W-1:0]      acc
);

    localparam int NCOL  = NUM_STATES + NUM_INPUTS;
    localparam int COL_W = $clog2(NCOL);
    localparam int G_BASE = NUM_STATES * NUM_STATES;
    localparam int H_BASE = G_BASE + NUM_STATES * NUM_INPUTS;

    logic signed [ssf_pkg::COEF_W-1:0] coef_reg [NCOL];
    logic signed [ssf_pkg::PROD_W-1:0] prod_reg;
    logic                              acc_en_reg;
    logic signed [ssf_pkg::ACC_W-1:0]  acc_reg;

    for (genvar c = 0; c < NCOL; c++)
    begin : g_col
        localparam int ADDR = (LANE < NUM_STATES)
            ? ((c < NUM_STATES) ? LANE * NUM_STATES + c
                                : G_BASE + LANE * NUM_INPUTS + (c - NUM_STATES))
            : ((c < NUM_STATES) ? H_BASE + (LANE - NUM_STATES) * NUM_STATES + c : -1);
        localparam logic IN_RANGE = (ADDR >= 0) && (ADDR < 2 ** ssf_pkg::COEF_IDX_W);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_reg[c] <= '0;
            end
            else if (IN_RANGE && coef_wr.en &&
                     coef_wr.index == ADDR[ssf_pkg::COEF_IDX_W-1:0])
            begin
                coef_reg[c] <= coef_wr.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef_reg[ctrl.col[COL_W-1:0]] * opnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            acc_en_reg <= ctrl.mul_en;
            if (ctrl.start)
            begin
                acc_reg <= '0;
            end
            else if (acc_en_reg)
            begin
                acc_reg <= acc_reg + ssf_pkg::ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/ssf_merge.sv */
// Merge stage: rounds and saturates every lane sum, holds the state vector.
// Depends on ssf_pkg for widths and saturation bounds.
module ssf_merge #(
    parameter int NUM_STATES  = 4,
    parameter int NUM_OUTPUTS = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  commit,
    input  logic signed [ssf_pkg::ACC_W-1:0]      lane_acc [NUM_STATES + NUM_OUTPUTS],
    output logic signed [ssf_pkg::SAMPLE_W-1:0]   state_x  [NUM_STATES],
    output logic signed [ssf_pkg::SAMPLE_W-1:0]   y_a,
    output logic signed [ssf_pkg::SAMPLE_W-1:0]   y_b
);

    localparam int NLANES = NUM_STATES + NUM_OUTPUTS;
    localparam int SH_W   = ssf_pkg::ACC_W - 16;

    function automatic logic signed [ssf_pkg::SAMPLE_W-1:0] round_sat(
        input logic signed [ssf_pkg::ACC_W-1:0] a
    );
        logic signed [ssf_pkg::ACC_W-1:0] biased;
        logic signed [SH_W-1:0]           r;
        biased = a + ssf_pkg::ACC_W'(32768);
        r      = biased[ssf_pkg::ACC_W-1:16];
        if (r > SH_W'(ssf_pkg::Q_MAX))
            return ssf_pkg::Q_MAX;
        else if (r < SH_W'(ssf_pkg::Q_MIN))
            return ssf_pkg::Q_MIN;
        else
            return r[ssf_pkg::SAMPLE_W-1:0];
    endfunction

    logic signed [ssf_pkg::SAMPLE_W-1:0] rs [NLANES];
    logic signed [ssf_pkg::SAMPLE_W-1:0] x_reg [NUM_STATES];

    always_comb
    begin
        for (int l = 0; l < NLANES; l++)
        begin
            rs[l] = round_sat(lane_acc[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                x_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                x_reg[i] <= rs[i];
            end
        end
    end

    assign state_x = x_reg;
    assign y_a     = rs[NUM_STATES];

    if (NUM_OUTPUTS > 1)
    begin : g_two_out
        assign y_b = rs[NUM_STATES + 1];
    end
    else
    begin : g_one_out
        assign y_b = '0;
    end

endmodule

/* rtl/state_space_filter_step.sv */
// Top level of the discrete state-space filter: clamp, sequencer, lanes, output register.
// Depends on ssf_pkg, ssf_lane, ssf_merge and the assertion macro header.
//
// Usage:
//   Input stream s_*: s_tuser is the mode (0 sample step, 1 coefficient write).
//   A coefficient write gives no output transfer.
//   A sample step gives one output transfer on m_*: out_a, out_b in m_tdata and the
//   clamp flag in m_tuser. y = H*x uses the state before the step; x then becomes
//   F*x + G*u, every value rounded half up and saturated to Q8.16.
//   One lane per state row and per output row runs side by side; each lane walks
//   its NUM_STATES + NUM_INPUTS columns, one multiply per cycle.
//   A sample step runs through ST_MAC, ST_DRAIN and ST_FINISH; in ST_FINISH the result
//   is loaded into the output register that drives m_tvalid, and the block takes the
//   next item only once it is back in ST_IDLE after that load.
//   Reset clears the state vector, all coefficients and the clamp registers
//   (clamping off, bounds at full range); the block is ready right after reset.
//   A stalled receiver holds the result in the output register; a new sample
//   step may run meanwhile and waits to load until that result is taken.
//   Write the cfg port only while the block is idle.
`include "state_space_filter_step_macros.svh"

module state_space_filter_step #(
    parameter int NUM_STATES  = 4,
    parameter int NUM_INPUTS  = 2,
    parameter int NUM_OUTPUTS = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [23:0] sample_a, [47:24] sample_b, [52:48] coef_index, [70:53] coef_value
    input  logic [71:0]                        s_tdata,
    // [0] mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [23:0] out_a, [47:24] out_b
    output logic [47:0]                        m_tdata,
    // [0] clamped
    output logic                               m_tuser,
    input  logic                               cfg_wen,
    input  logic [ssf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssf_pkg::SAMPLE_W-1:0]       cfg_data
);

    localparam int NCOL   = NUM_STATES + NUM_INPUTS;
    localparam int NLANES = NUM_STATES + NUM_OUTPUTS;
    localparam int COL_W  = $clog2(NCOL);
    localparam int SW     = ssf_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [COL_W-1:0]        col_reg;
    logic                    clamp_en_reg;
    logic signed [SW-1:0]    low_reg  [2];
    logic signed [SW-1:0]    high_reg [2];
    logic signed [SW-1:0]    u_reg    [NUM_INPUTS];
    logic                    flag_reg;
    logic                    m_valid_reg;
    logic [47:0]             m_data_reg;
    logic                    m_user_reg;

    logic signed [SW-1:0]    sample_in [2];
    logic signed [SW-1:0]    u_next    [NUM_INPUTS];
    logic                    flag_next;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    commit;
    logic signed [SW-1:0]    col_val [NCOL];
    logic signed [SW-1:0]    opnd;
    logic signed [SW-1:0]    state_x [NUM_STATES];
    logic signed [SW-1:0]    y_a;
    logic signed [SW-1:0]    y_b;
    logic signed [ssf_pkg::ACC_W-1:0] lane_acc [NLANES];
    ssf_pkg::ssf_ctrl_t      ctrl;
    ssf_pkg::ssf_coef_wr_t   coef_wr;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_valid_reg && m_tready;
    assign commit   = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    assign sample_in[0] = s_tdata[23:0];
    assign sample_in[1] = s_tdata[47:24];

    always_comb
    begin
        flag_next = 1'b0;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            u_next[i] = sample_in[i];
            if (clamp_en_reg)
            begin
                if (u_next[i] < low_reg[i])
                    u_next[i] = low_reg[i];
                if (u_next[i] > high_reg[i])
                    u_next[i] = high_reg[i];
                if (u_next[i] != sample_in[i])
                    flag_next = 1'b1;
            end
        end
    end

    assign coef_wr.en    = in_xfer && (s_tuser == ssf_pkg::MODE_COEF);
    assign coef_wr.index = s_tdata[52:48];
    assign coef_wr.value = s_tdata[70:53];

    always_comb
    begin
        for (int j = 0; j < NUM_STATES; j++)
        begin
            col_val[j] = state_x[j];
        end
        for (int k = 0; k < NUM_INPUTS; k++)
        begin
            col_val[NUM_STATES + k] = u_reg[k];
        end
        opnd = '0;
        for (int j = 0; j < NCOL; j++)
        begin
            if (col_reg == COL_W'(j))
                opnd = col_val[j];
        end
    end

    assign ctrl.start  = in_xfer && (s_tuser == ssf_pkg::MODE_SAMPLE);
    assign ctrl.mul_en = (state_reg == ST_MAC);
    assign ctrl.col    = ssf_pkg::COL_MAX_W'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_en_reg <= 1'b0;
            low_reg[0]   <= ssf_pkg::Q_MIN;
            high_reg[0]  <= ssf_pkg::Q_MAX;
            low_reg[1]   <= ssf_pkg::Q_MIN;
            high_reg[1]  <= ssf_pkg::Q_MAX;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                ssf_pkg::REG_CLAMP_EN: clamp_en_reg <= cfg_data[0];
                ssf_pkg::REG_LOW_A:    low_reg[0]   <= cfg_data;
                ssf_pkg::REG_HIGH_A:   high_reg[0]  <= cfg_data;
                ssf_pkg::REG_LOW_B:    low_reg[1]   <= cfg_data;
                ssf_pkg::REG_HIGH_B:   high_reg[1]  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            u_reg    <= u_next;
            flag_reg <= flag_next;
        end
        if (commit)
        begin
            m_data_reg <= {y_b, y_a};
            m_user_reg <= flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
                m_valid_reg <= 1'b1;
            else if (out_xfer)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    col_reg <= '0;
                    if (ctrl.start)
                        state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    if (col_reg == COL_W'(NCOL - 1))
                        state_reg <= ST_DRAIN;
                    else
                        col_reg <= col_reg + 1'b1;
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (commit)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    for (genvar l = 0; l < NLANES; l++)
    begin : g_lane
        ssf_lane #(
            .NUM_STATES (NUM_STATES),
            .NUM_INPUTS (NUM_INPUTS),
            .LANE       (l)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .coef_wr (coef_wr),
            .opnd    (opnd),
            .acc     (lane_acc[l])
        );
    end

    ssf_merge #(
        .NUM_STATES  (NUM_STATES),
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .lane_acc (lane_acc),
        .state_x  (state_x),
        .y_a      (y_a),
        .y_b      (y_b)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `SSF_ASSERT_NEXT(a_sample_busy, in_xfer && s_tuser == ssf_pkg::MODE_SAMPLE, !s_tready, "sample transfer did not start the sequencer")
    `SSF_ASSERT_NEXT(a_coef_idle, in_xfer && s_tuser == ssf_pkg::MODE_COEF, s_tready && !m_tvalid || s_tready, "coefficient write left the block busy")
    `SSF_ASSERT_SAME(a_result_src, $rose(m_tvalid), $past(state_reg == ST_FINISH), "result appeared outside the finish step")
    `SSF_ASSERT_SAME(a_col_range, state_reg == ST_MAC, col_reg <= COL_W'(NCOL - 1), "column counter out of range")

endmodule

/* verif/ssf_checker.sv */
`timescale 1ns / 100ps
// Checker for state_space_filter_step: watches the input, output and register ports,
// predicts each filter output from its own copy of the state and coefficients, compares.
// Depends on ssf_pkg only.
module ssf_checker
    import ssf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [71:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam int N_X    = 4;
    localparam int N_U    = 2;
    localparam int N_Y    = 2;
    localparam int G_BASE = N_X * N_X;
    localparam int H_BASE = G_BASE + N_X * N_U;
    localparam int DEPTH  = H_BASE + N_Y * N_X;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_a;
        logic signed [SAMPLE_W-1:0] out_b;
        logic                       clamped;
    } filter_out_t;

    logic signed [SAMPLE_W-1:0] state_x [N_X];
    logic signed [COEF_W-1:0]   coef_mem [DEPTH];
    logic                       clamp_on;
    logic signed [SAMPLE_W-1:0] lo_bound [N_U];
    logic signed [SAMPLE_W-1:0] hi_bound [N_U];
    filter_out_t                expected_outputs [$];
    filter_out_t                want;
    filter_out_t                got;
    int                         mismatches;

    function automatic logic signed [SAMPLE_W-1:0] round_saturate(input longint acc);
        longint r;
        r = (acc + 64'sd32768) >>> 16;
        if (r > Q_MAX)
            return Q_MAX;
        if (r < Q_MIN)
            return Q_MIN;
        return r[SAMPLE_W-1:0];
    endfunction

    task automatic step_filter(input logic signed [SAMPLE_W-1:0] sa,
                               input logic signed [SAMPLE_W-1:0] sb,
                               output filter_out_t res);
        logic signed [SAMPLE_W-1:0] u [N_U];
        logic signed [SAMPLE_W-1:0] nx [N_X];
        logic signed [SAMPLE_W-1:0] v;
        longint acc;
        u[0] = sa;
        u[1] = sb;
        res.clamped = 1'b0;
        if (clamp_on)
        begin
            for (int i = 0; i < N_U; i++)
            begin
                v = u[i];
                if (v < lo_bound[i])
                    v = lo_bound[i];
                if (v > hi_bound[i])
                    v = hi_bound[i];
                if (v != u[i])
                    res.clamped = 1'b1;
                u[i] = v;
            end
        end
        for (int i = 0; i < N_Y; i++)
        begin
            acc = 0;
            for (int k = 0; k < N_X; k++)
                acc += longint'(coef_mem[H_BASE + i * N_X + k]) * longint'(state_x[k]);
            if (i == 0)
                res.out_a = round_saturate(acc);
            else
                res.out_b = round_saturate(acc);
        end
        for (int i = 0; i < N_X; i++)
        begin
            acc = 0;
            for (int k = 0; k < N_X; k++)
                acc += longint'(coef_mem[i * N_X + k]) * longint'(state_x[k]);
            for (int k = 0; k < N_U; k++)
                acc += longint'(coef_mem[G_BASE + i * N_U + k]) * longint'(u[k]);
            nx[i] = round_saturate(acc);
        end
        for (int i = 0; i < N_X; i++)
            state_x[i] = nx[i];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (state_x[i])
                state_x[i] = '0;
            foreach (coef_mem[i])
                coef_mem[i] = '0;
            clamp_on = 1'b0;
            foreach (lo_bound[i])
            begin
                lo_bound[i] = Q_MIN;
                hi_bound[i] = Q_MAX;
            end
            expected_outputs.delete();
            mismatches = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $error("unexpected output transfer: out_a %0d out_b %0d clamped %0d",
                           $signed(m_tdata[23:0]), $signed(m_tdata[47:24]), m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (m_tdata[23:0] !== want.out_a)
                    begin
                        $error("out_a: expected %0d, actual %0d",
                               want.out_a, $signed(m_tdata[23:0]));
                        mismatches++;
                    end
                    if (m_tdata[47:24] !== want.out_b)
                    begin
                        $error("out_b: expected %0d, actual %0d",
                               want.out_b, $signed(m_tdata[47:24]));
                        mismatches++;
                    end
                    if (m_tuser !== want.clamped)
                    begin
                        $error("clamped: expected %0d, actual %0d", want.clamped, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_CLAMP_EN: clamp_on    = cfg_data[0];
                    REG_LOW_A:    lo_bound[0] = cfg_data;
                    REG_HIGH_A:   hi_bound[0] = cfg_data;
                    REG_LOW_B:    lo_bound[1] = cfg_data;
                    REG_HIGH_B:   hi_bound[1] = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == MODE_COEF)
                begin
                    if (s_tdata[52:48] < DEPTH)
                        coef_mem[s_tdata[52:48]] = s_tdata[70:53];
                end
                else
                begin
                    step_filter(s_tdata[23:0], s_tdata[47:24], got);
                    expected_outputs.push_back(got);
                end
            end
            errors  <= mismatches;
            pending <= expected_outputs.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Top of the state_space_filter_step testbench: clock, reset, stimulus and verdict.
// Depends on ssf_pkg, the filter RTL and ssf_checker.
module tb_top;
    import ssf_pkg::*;

    localparam int G_BASE      = 16;
    localparam int H_BASE      = 24;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 110;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sh1FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 18'sh20000;
    localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sh10000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata   = '0;
    logic                 s_tuser   = MODE_SAMPLE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CLAMP_EN;
    logic [SAMPLE_W-1:0]  cfg_data  = '0;
    logic                 quiet     = 1'b0;
    int                   errors;
    int                   pending;
    int                   stalled   = 0;

    state_space_filter_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssf_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(99) >= 27);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            stalled <= 0;
        else if (stalled >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stalled <= stalled + 1;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int r;
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return SAMPLE_W'($urandom);
            default:
            begin
                r = int'($urandom_range(0, 524288)) - 262144;
                return r[SAMPLE_W-1:0];
            end
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        int r;
        case ($urandom_range(9))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return COEF_W'($urandom);
            default:
            begin
                r = int'($urandom_range(0, 32768)) - 16384;
                return r[COEF_W-1:0];
            end
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [71:0] word);
        while (!quiet && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] sa,
                               input logic signed [SAMPLE_W-1:0] sb);
        logic [71:0] word;
        word = 72'({$urandom, $urandom, $urandom});
        word[71]    = 1'b0;
        word[23:0]  = sa;
        word[47:24] = sb;
        send_item(MODE_SAMPLE, word);
    endtask

    task automatic send_coef(input int idx,
                             input logic signed [COEF_W-1:0] value);
        logic [71:0] word;
        word = 72'({$urandom, $urandom, $urandom});
        word[71]    = 1'b0;
        word[52:48] = COEF_IDX_W'(idx);
        word[70:53] = value;
        send_item(MODE_COEF, word);
    endtask

    // hold off the sender until every result is back, then let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic en,
                             input logic signed [SAMPLE_W-1:0] la,
                             input logic signed [SAMPLE_W-1:0] ha,
                             input logic signed [SAMPLE_W-1:0] lb,
                             input logic signed [SAMPLE_W-1:0] hb);
        logic [SAMPLE_W-1:0]  vals [5];
        logic [CFG_IDX_W-1:0] regs [5];
        vals = '{{23'd0, en}, la, ha, lb, hb};
        regs = '{REG_CLAMP_EN, REG_LOW_A, REG_HIGH_A, REG_LOW_B, REG_HIGH_B};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] t;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(Q_MAX, Q_MIN);
        send_coef(G_BASE, COEF_MAX);
        send_coef(G_BASE + 1, COEF_MIN);
        send_coef(0, COEF_MAX);
        send_coef(5, COEF_ONE);
        send_coef(4, COEF_MIN);
        send_coef(H_BASE, COEF_ONE);
        send_coef(H_BASE + 1, COEF_MIN);
        send_coef(H_BASE + 5, COEF_MAX);
        send_coef(H_BASE + 7, -18'sd1);
        send_sample(Q_MAX, Q_MIN);
        send_sample(Q_MIN, Q_MAX);
        send_sample(24'sd0, 24'sd0);
        send_sample(-24'sd1, 24'sd1);
        drain();

        // sample b bounds crossed: low test first, then high
        configure(1'b1, -24'sd1000, 24'sd1000, 24'sd500, -24'sd500);
        send_sample(Q_MIN, Q_MAX);
        send_sample(24'sd0, 24'sd0);
        send_sample(24'sd999, -24'sd600);
        drain();

        configure(1'b1, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_sample(Q_MAX, Q_MIN);
        send_sample(24'sd7, 24'sd8);

        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            lo = rand_sample();
            hi = rand_sample();
            if (lo > hi)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            case (phase)
                0: configure(1'b0, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
                1: configure(1'b1, lo, hi, rand_sample(), Q_MAX);
                2: configure(1'b1, hi, lo, lo, hi);
                3: configure(1'b1, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
                default: configure(1'b1, lo, hi, hi, lo);
            endcase
            quiet <= (phase == 2);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 25)
                    send_coef($urandom_range(31), rand_coef());
                else
                    send_sample(rand_sample(), rand_sample());
            end
        end

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* state_space_filter_step.f */
+incdir+rtl
rtl/ssf_pkg.sv
rtl/ssf_lane.sv
rtl/ssf_merge.sv
rtl/state_space_filter_step.sv
verif/ssf_checker.sv
verif/tb_top.sv
